>>> design/rsn_pkg.sv
package rsn_pkg;

    localparam int RANK_W     = 10;
    localparam int PROC_W     = 11;
    localparam int CELL_W     = 16;
    localparam int PLANE_W    = 2 * (PROC_W - 1) + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [PROC_W-1:0] MAX_PROCS = 11'd1024;

    localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_PROCS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROCS_X     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PROCS_Y     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PROCS_Z     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_X    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_Y    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_Z    = 3'd7;

    localparam int FRONT_STAGES = 21;
    localparam int QUEUE_DEPTH  = 32;
    localparam int QUEUE_AW     = 5;
    localparam int CREDIT_W     = 6;

    // effective grid, clamped
    typedef struct packed {
        logic [PROC_W-1:0]  nx;
        logic [PROC_W-1:0]  ny;
        logic [PROC_W-1:0]  nz;
        logic [PLANE_W-1:0] plane;
        logic [CELL_W-1:0]  gx;
        logic [CELL_W-1:0]  gy;
        logic [CELL_W-1:0]  gz;
    } t_geom;

    typedef struct packed {
        logic [CELL_W-1:0] qx;
        logic [CELL_W-1:0] qy;
        logic [CELL_W-1:0] qz;
        logic [RANK_W-1:0] rx;
        logic [RANK_W-1:0] ry;
        logic [RANK_W-1:0] rz;
        logic [RANK_W-1:0] xp;
        logic [RANK_W-1:0] yp;
        logic [RANK_W-1:0] zp;
        logic [RANK_W-1:0] xup;
    } t_mid;

    typedef struct packed {
        logic [CELL_W-1:0] x_start;
        logic [CELL_W-1:0] x_end;
        logic [CELL_W-1:0] y_start;
        logic [CELL_W-1:0] y_end;
        logic [CELL_W-1:0] z_start;
        logic [CELL_W-1:0] z_end;
        logic [RANK_W-1:0] west;
        logic [RANK_W-1:0] east;
        logic [RANK_W-1:0] south;
        logic [RANK_W-1:0] north;
        logic [RANK_W-1:0] below;
        logic [RANK_W-1:0] above;
    } t_res;

endpackage

>>> design/rsn_front.sv
module rsn_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_vld,
    input  logic [rsn_pkg::RANK_W-1:0] i_rank,
    input  rsn_pkg::t_geom            i_geom,
    output logic                      o_vld,
    output rsn_pkg::t_mid             o_mid
);
    import rsn_pkg::*;

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic [CELL_W-1:0] qx;
        logic [CELL_W-1:0] qy;
        logic [CELL_W-1:0] qz;
        logic [PROC_W-1:0] rx;
        logic [PROC_W-1:0] ry;
        logic [PROC_W-1:0] rz;
        logic [RANK_W-1:0] xq;
        logic [PROC_W-1:0] ra;
        logic [RANK_W-1:0] bd;
        logic [RANK_W-1:0] yq;
        logic [PROC_W-1:0] rb;
        logic [PROC_W-1:0] cd;
        logic [PROC_W-1:0] rc;
    } t_fst;

    // one restoring division step: {quotient bit, new remainder}
    function automatic logic [PROC_W:0] div_step(logic [PROC_W-1:0] rem, logic b,
                                                 logic [PLANE_W-1:0] d);
        logic [PLANE_W:0] sh;
        logic             q;
        sh = {{(PLANE_W - PROC_W){1'b0}}, rem, b};
        q  = (sh >= {1'b0, d});
        if (q) begin
            sh = sh - {1'b0, d};
        end
        return {q, sh[PROC_W-1:0]};
    endfunction

    localparam int PAD = PLANE_W - PROC_W;

    t_fst                    r_st [FRONT_STAGES];
    logic [FRONT_STAGES-1:0] r_vld;
    t_fst                    s_init;

    always_comb begin
        s_init      = '0;
        s_init.rank = i_rank;
    end

    for (genvar gi = 0; gi < FRONT_STAGES; gi++) begin : g_stage
        localparam int AXB = (gi < 16) ? 15 - gi : 0;
        localparam int AB  = (gi < 10) ? 9 - gi : 0;
        localparam int BB  = (gi >= 10 && gi < 20) ? 19 - gi : 0;
        localparam int CB  = (gi >= 10) ? 20 - gi : 0;
        t_fst s_prev;
        t_fst s_nxt;

        if (gi == 0) begin : g_first
            assign s_prev = s_init;
        end else begin : g_rest
            assign s_prev = r_st[gi-1];
        end

        always_comb begin
            logic [PROC_W:0] st;
            s_nxt = s_prev;
            st    = '0;
            // cells over processes, one bit per stage for each axis
            if (gi < 16) begin
                st = div_step(s_nxt.rx, i_geom.gx[AXB], {{PAD{1'b0}}, i_geom.nx});
                s_nxt.qx = {s_nxt.qx[CELL_W-2:0], st[PROC_W]};
                s_nxt.rx = st[PROC_W-1:0];
                st = div_step(s_nxt.ry, i_geom.gy[AXB], {{PAD{1'b0}}, i_geom.ny});
                s_nxt.qy = {s_nxt.qy[CELL_W-2:0], st[PROC_W]};
                s_nxt.ry = st[PROC_W-1:0];
                st = div_step(s_nxt.rz, i_geom.gz[AXB], {{PAD{1'b0}}, i_geom.nz});
                s_nxt.qz = {s_nxt.qz[CELL_W-2:0], st[PROC_W]};
                s_nxt.rz = st[PROC_W-1:0];
            end
            // rank over plane gives x position
            if (gi < 10) begin
                st = div_step(s_nxt.ra, s_nxt.rank[AB], i_geom.plane);
                s_nxt.xq = {s_nxt.xq[RANK_W-2:0], st[PROC_W]};
                s_nxt.ra = st[PROC_W-1:0];
            end
            if (gi == 10) begin
                s_nxt.bd = s_nxt.ra[RANK_W-1:0];
                s_nxt.cd = {1'b0, s_nxt.xq} + 11'd1;
            end
            // remainder over line gives y and z positions
            if (gi >= 10 && gi < 20) begin
                st = div_step(s_nxt.rb, s_nxt.bd[BB], {{PAD{1'b0}}, i_geom.nz});
                s_nxt.yq = {s_nxt.yq[RANK_W-2:0], st[PROC_W]};
                s_nxt.rb = st[PROC_W-1:0];
            end
            // (x + 1) mod nx for the east neighbor
            if (gi >= 10) begin
                st = div_step(s_nxt.rc, s_nxt.cd[CB], {{PAD{1'b0}}, i_geom.nx});
                s_nxt.rc = st[PROC_W-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            r_st[gi] <= s_nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[FRONT_STAGES-2:0], i_vld};
        end
    end

    assign o_vld     = r_vld[FRONT_STAGES-1];
    assign o_mid.qx  = r_st[FRONT_STAGES-1].qx;
    assign o_mid.qy  = r_st[FRONT_STAGES-1].qy;
    assign o_mid.qz  = r_st[FRONT_STAGES-1].qz;
    assign o_mid.rx  = r_st[FRONT_STAGES-1].rx[RANK_W-1:0];
    assign o_mid.ry  = r_st[FRONT_STAGES-1].ry[RANK_W-1:0];
    assign o_mid.rz  = r_st[FRONT_STAGES-1].rz[RANK_W-1:0];
    assign o_mid.xp  = r_st[FRONT_STAGES-1].xq;
    assign o_mid.yp  = r_st[FRONT_STAGES-1].yq;
    assign o_mid.zp  = r_st[FRONT_STAGES-1].rb[RANK_W-1:0];
    assign o_mid.xup = r_st[FRONT_STAGES-1].rc[RANK_W-1:0];

endmodule

>>> design/rsn_queue.sv
module rsn_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rsn_pkg::t_mid i_data,
    input  logic          i_pop,
    output logic          o_empty,
    output rsn_pkg::t_mid o_data
);
    import rsn_pkg::*;

    t_mid                r_buf [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wptr;
    logic [QUEUE_AW-1:0] r_rptr;
    logic [CREDIT_W-1:0] r_cnt;
    t_mid                r_data;
    logic                r_dvld;

    logic pop_ok;
    logic slot_free;
    logic mem_empty;
    logic rd_mem;
    logic wr_mem;

    // output register in front of the memory; an item goes straight to it
    // when the memory holds nothing and the register is free or being popped
    assign pop_ok    = i_pop && r_dvld;
    assign slot_free = !r_dvld || pop_ok;
    assign mem_empty = (r_cnt == '0);
    assign rd_mem    = slot_free && !mem_empty;
    assign wr_mem    = i_push && !(slot_free && mem_empty);

    // never overfills: the top level holds back pushes by credit
    always_ff @(posedge i_clk) begin
        if (wr_mem) begin
            r_buf[r_wptr] <= i_data;
        end
        if (rd_mem) begin
            r_data <= r_buf[r_rptr];
        end else if (slot_free && i_push) begin
            r_data <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
            r_dvld <= 1'b0;
        end else begin
            if (wr_mem) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (rd_mem) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_cnt <= r_cnt + CREDIT_W'(wr_mem) - CREDIT_W'(rd_mem);
            if (slot_free) begin
                r_dvld <= !mem_empty || i_push;
            end
        end
    end

    assign o_empty = !r_dvld;
    assign o_data  = r_data;

endmodule

>>> design/rsn_back.sv
module rsn_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rsn_pkg::t_geom i_geom,
    input  logic           i_q_empty,
    input  rsn_pkg::t_mid  i_q_data,
    output logic           o_q_pop,
    input  logic           i_pop,
    output logic           o_empty,
    output rsn_pkg::t_res  o_res
);
    import rsn_pkg::*;

    logic [2:0][CELL_W-1:0] r_q, r_ma, r_mb, r_mc;
    logic [2:0]             r_lt;
    logic [RANK_W-1:0]      r_xpp, r_xdp, r_xup, r_ypl, r_ydl, r_yul, r_zp, r_zd, r_zu;
    logic                   r_v1;
    logic                   r_v2;
    t_res                   r_res;

    logic [2:0][CELL_W-1:0] n_q, n_ma, n_mb, n_mc;
    logic [2:0]             n_lt;
    logic [RANK_W-1:0]      n_xpp, n_xdp, n_xup, n_ypl, n_ydl, n_yul, n_zd, n_zu;
    t_res                   n_res;
    logic                   adv1;
    logic                   adv2;

    assign adv2    = !r_v2 || i_pop;
    assign adv1    = !r_v1 || adv2;
    assign o_q_pop = adv1 && !i_q_empty;

    // stage 1: products
    always_comb begin
        logic [2:0][CELL_W-1:0] aq;
        logic [2:0][RANK_W-1:0] ar, ap;
        logic [CELL_W-1:0]      q1;
        logic [2*CELL_W-1:0]    pr;
        logic [2*RANK_W-1:0]    pn;
        logic [RANK_W-1:0]      xdn, ydn, yup, zdn, zup;
        logic [PROC_W-1:0]      t;
        aq = {i_q_data.qz, i_q_data.qy, i_q_data.qx};
        ar = {i_q_data.rz, i_q_data.ry, i_q_data.rx};
        ap = {i_q_data.zp, i_q_data.yp, i_q_data.xp};
        for (int a = 0; a < 3; a++) begin
            q1       = aq[a] + 16'd1;
            n_q[a]   = aq[a];
            n_lt[a]  = (ap[a] < ar[a]);
            pr       = q1 * {6'd0, ap[a]};
            n_ma[a]  = pr[CELL_W-1:0];
            pr       = q1 * {6'd0, ar[a]};
            n_mb[a]  = pr[CELL_W-1:0];
            pr       = aq[a] * ({6'd0, ap[a]} - {6'd0, ar[a]});
            n_mc[a]  = pr[CELL_W-1:0];
        end
        t   = i_geom.nx - 11'd1;
        xdn = (i_q_data.xp == '0) ? t[RANK_W-1:0] : i_q_data.xp - 1'b1;
        t   = i_geom.ny - 11'd1;
        ydn = (i_q_data.yp == '0) ? t[RANK_W-1:0] : i_q_data.yp - 1'b1;
        t   = {1'b0, i_q_data.yp} + 11'd1;
        yup = (t == i_geom.ny) ? '0 : t[RANK_W-1:0];
        t   = i_geom.nz - 11'd1;
        zdn = (i_q_data.zp == '0) ? t[RANK_W-1:0] : i_q_data.zp - 1'b1;
        t   = {1'b0, i_q_data.zp} + 11'd1;
        zup = (t == i_geom.nz) ? '0 : t[RANK_W-1:0];
        // neighbor ranks only need their low bits
        pn    = i_q_data.xp * i_geom.plane[RANK_W-1:0];
        n_xpp = pn[RANK_W-1:0];
        pn    = xdn * i_geom.plane[RANK_W-1:0];
        n_xdp = pn[RANK_W-1:0];
        pn    = i_q_data.xup * i_geom.plane[RANK_W-1:0];
        n_xup = pn[RANK_W-1:0];
        pn    = i_q_data.yp * i_geom.nz[RANK_W-1:0];
        n_ypl = pn[RANK_W-1:0];
        pn    = ydn * i_geom.nz[RANK_W-1:0];
        n_ydl = pn[RANK_W-1:0];
        pn    = yup * i_geom.nz[RANK_W-1:0];
        n_yul = pn[RANK_W-1:0];
        n_zd  = zdn;
        n_zu  = zup;
    end

    // stage 2: sums
    always_comb begin
        logic [2:0][CELL_W-1:0] lo, hi;
        for (int a = 0; a < 3; a++) begin
            lo[a] = r_lt[a] ? r_ma[a] : r_mb[a] + r_mc[a];
            hi[a] = lo[a] + r_q[a] + CELL_W'(r_lt[a]);
        end
        n_res.x_start = lo[0];
        n_res.x_end   = hi[0];
        n_res.y_start = lo[1];
        n_res.y_end   = hi[1];
        n_res.z_start = lo[2];
        n_res.z_end   = hi[2];
        n_res.west    = r_xdp + r_ypl + r_zp;
        n_res.east    = r_xup + r_ypl + r_zp;
        n_res.south   = r_xpp + r_ydl + r_zp;
        n_res.north   = r_xpp + r_yul + r_zp;
        n_res.below   = r_xpp + r_ypl + r_zd;
        n_res.above   = r_xpp + r_ypl + r_zu;
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_q   <= n_q;
            r_lt  <= n_lt;
            r_ma  <= n_ma;
            r_mb  <= n_mb;
            r_mc  <= n_mc;
            r_xpp <= n_xpp;
            r_xdp <= n_xdp;
            r_xup <= n_xup;
            r_ypl <= n_ypl;
            r_ydl <= n_ydl;
            r_yul <= n_yul;
            r_zp  <= i_q_data.zp;
            r_zd  <= n_zd;
            r_zu  <= n_zu;
        end
        if (adv2) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= !i_q_empty;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
        end
    end

    assign o_empty = !r_v2;
    assign o_res   = r_res;

endmodule

>>> design/rank_subdomain_and_neighbors_top.sv
// throughput: one item per cycle; the 21-stage divider front runs at a fixed pace and
// is throttled by credit against the 32-entry queue feeding the 2-stage back end
// reset: synchronous active-low; clears all queues and pipelines, sets split_mode to 1
// and every count register to 1
module rank_subdomain_and_neighbors_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rsn_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rsn_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          push,
    output logic                          full,
    input  logic [rsn_pkg::RANK_W-1:0]     i_rank,
    output logic                          empty,
    input  logic                          pop,
    output logic [rsn_pkg::CELL_W-1:0]     o_x_start,
    output logic [rsn_pkg::CELL_W-1:0]     o_x_end,
    output logic [rsn_pkg::CELL_W-1:0]     o_y_start,
    output logic [rsn_pkg::CELL_W-1:0]     o_y_end,
    output logic [rsn_pkg::CELL_W-1:0]     o_z_start,
    output logic [rsn_pkg::CELL_W-1:0]     o_z_end,
    output logic [rsn_pkg::RANK_W-1:0]     o_west_rank,
    output logic [rsn_pkg::RANK_W-1:0]     o_east_rank,
    output logic [rsn_pkg::RANK_W-1:0]     o_south_rank,
    output logic [rsn_pkg::RANK_W-1:0]     o_north_rank,
    output logic [rsn_pkg::RANK_W-1:0]     o_below_rank,
    output logic [rsn_pkg::RANK_W-1:0]     o_above_rank
);
    import rsn_pkg::*;

    logic                r_split_mode;
    logic [PROC_W-1:0]   r_total_procs, r_procs_x, r_procs_y, r_procs_z;
    logic [CELL_W-1:0]   r_global_x, r_global_y, r_global_z;
    logic [CREDIT_W-1:0] r_credit;

    t_geom geom;
    logic  push_ok;
    logic  f_vld;
    t_mid  f_mid;
    logic  q_empty;
    logic  q_pop;
    t_mid  q_data;
    t_res  res;

    function automatic logic [PROC_W-1:0] clamp_procs(logic [PROC_W-1:0] v);
        if (v == '0) begin
            return 11'd1;
        end else if (v > MAX_PROCS) begin
            return MAX_PROCS;
        end
        return v;
    endfunction

    function automatic logic [CELL_W-1:0] clamp_cells(logic [CELL_W-1:0] v);
        return (v == '0) ? 16'd1 : v;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_split_mode  <= 1'b1;
            r_total_procs <= 11'd1;
            r_procs_x     <= 11'd1;
            r_procs_y     <= 11'd1;
            r_procs_z     <= 11'd1;
            r_global_x    <= 16'd1;
            r_global_y    <= 16'd1;
            r_global_z    <= 16'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SPLIT_MODE:  r_split_mode  <= i_cfg_data[0];
                CFG_TOTAL_PROCS: r_total_procs <= i_cfg_data[PROC_W-1:0];
                CFG_PROCS_X:     r_procs_x     <= i_cfg_data[PROC_W-1:0];
                CFG_PROCS_Y:     r_procs_y     <= i_cfg_data[PROC_W-1:0];
                CFG_PROCS_Z:     r_procs_z     <= i_cfg_data[PROC_W-1:0];
                CFG_GLOBAL_X:    r_global_x    <= i_cfg_data;
                CFG_GLOBAL_Y:    r_global_y    <= i_cfg_data;
                CFG_GLOBAL_Z:    r_global_z    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // x-only mode is a total x 1 x 1 grid
    always_comb begin
        logic [2*PROC_W-1:0] pl;
        geom.nx = r_split_mode ? clamp_procs(r_procs_x) : clamp_procs(r_total_procs);
        geom.ny = r_split_mode ? clamp_procs(r_procs_y) : 11'd1;
        geom.nz = r_split_mode ? clamp_procs(r_procs_z) : 11'd1;
        pl         = geom.ny * geom.nz;
        geom.plane = pl[PLANE_W-1:0];
        geom.gx    = clamp_cells(r_global_x);
        geom.gy    = clamp_cells(r_global_y);
        geom.gz    = clamp_cells(r_global_z);
    end

    // credit covers items in the front plus items held in the queue
    assign push_ok = push && !full;
    assign full    = (r_credit == CREDIT_W'(QUEUE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
        end else begin
            r_credit <= r_credit + CREDIT_W'(push_ok) - CREDIT_W'(q_pop);
        end
    end

    rsn_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (push_ok),
        .i_rank  (i_rank),
        .i_geom  (geom),
        .o_vld   (f_vld),
        .o_mid   (f_mid)
    );

    rsn_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_vld),
        .i_data  (f_mid),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_data)
    );

    rsn_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_geom    (geom),
        .i_q_empty (q_empty),
        .i_q_data  (q_data),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_res     (res)
    );

    assign o_x_start    = res.x_start;
    assign o_x_end      = res.x_end;
    assign o_y_start    = res.y_start;
    assign o_y_end      = res.y_end;
    assign o_z_start    = res.z_start;
    assign o_z_end      = res.z_end;
    assign o_west_rank  = res.west;
    assign o_east_rank  = res.east;
    assign o_south_rank = res.south;
    assign o_north_rank = res.north;
    assign o_below_rank = res.below;
    assign o_above_rank = res.above;

endmodule

>>> design/rsn_checker.sv
module rsn_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      push,
    input logic                      full,
    input logic                      empty,
    input logic                      pop,
    input logic [rsn_pkg::CELL_W-1:0] o_x_start,
    input logic [rsn_pkg::RANK_W-1:0] o_west_rank
);
    import rsn_pkg::*;

    // nothing is in flight right after reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !full && empty ##1 empty)
        else $error("results or full shown right after reset");

    // credit only grows on an accepted item
    a_full_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(full) |-> $past(push))
        else $error("full rose without an accepted item");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_x_start) && $stable(o_west_rank))
        else $error("waiting result changed");

    // a result has to pass the divider front, so none shows right after reset
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> empty)
        else $error("result appeared too early");

endmodule

bind rank_subdomain_and_neighbors_top rsn_checker u_rsn_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .push        (push),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .o_x_start   (o_x_start),
    .o_west_rank (o_west_rank)
);

>>> tb/rank_subdomain_and_neighbors_top_tb.sv
`timescale 1ns / 1ps

module rank_subdomain_and_neighbors_top_tb;
    import rsn_pkg::*;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = CFG_SPLIT_MODE;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  push = 1'b0;
    logic                  full;
    logic [RANK_W-1:0]     i_rank = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [CELL_W-1:0]     o_x_start, o_x_end, o_y_start, o_y_end, o_z_start, o_z_end;
    logic [RANK_W-1:0]     o_west_rank, o_east_rank, o_south_rank, o_north_rank;
    logic [RANK_W-1:0]     o_below_rank, o_above_rank;

    rank_subdomain_and_neighbors_top u_top (.*);

    // copy of the register file
    longint unsigned split_mode_r, total_procs_r, px_r, py_r, pz_r, gx_r, gy_r, gz_r;

    t_res expected_boxes[$];
    int   send_idle = 0;
    int   recv_idle = 0;
    int   fail_count = 0;

    initial forever #1 i_clk = ~i_clk;

    function automatic longint unsigned clamp_count(longint unsigned v, longint unsigned lim);
        if (v == 0) return 1;
        if (v > lim) return lim;
        return v;
    endfunction

    function automatic void split_axis(longint unsigned cells, longint unsigned parts,
                                       longint unsigned pos,
                                       output longint unsigned lo, output longint unsigned hi);
        longint unsigned q, r;
        q = cells / parts;
        r = cells - q * parts;
        if (pos < r) begin
            lo = (q + 1) * pos;
            hi = lo + q + 1;
        end else begin
            lo = (q + 1) * r + q * (pos - r);
            hi = lo + q;
        end
    endfunction

    function automatic longint unsigned wrap_down(longint unsigned pos, longint unsigned ext);
        return (pos == 0) ? ext - 1 : pos - 1;
    endfunction

    function automatic longint unsigned wrap_up(longint unsigned pos, longint unsigned ext);
        longint unsigned t;
        t = pos + 1;
        return (t >= ext) ? t % ext : t;
    endfunction

    function automatic t_res predict_box(logic [RANK_W-1:0] rank);
        longint unsigned gx, gy, gz, nx, ny, nz, plane, xp, yp, zp, rem, base;
        longint unsigned xs, xe, ys, ye, zs, ze;
        t_res res;
        gx = clamp_count(gx_r, 65535);
        gy = clamp_count(gy_r, 65535);
        gz = clamp_count(gz_r, 65535);
        if (split_mode_r == 0) begin
            nx = clamp_count(total_procs_r, MAX_PROCS);
            ny = 1;
            nz = 1;
        end else begin
            nx = clamp_count(px_r, MAX_PROCS);
            ny = clamp_count(py_r, MAX_PROCS);
            nz = clamp_count(pz_r, MAX_PROCS);
        end
        plane = ny * nz;
        xp = rank / plane;
        rem = rank - xp * plane;
        yp = rem / nz;
        zp = rem - yp * nz;
        split_axis(gx, nx, xp, xs, xe);
        if (split_mode_r == 0) begin
            ys = 0; ye = gy;
            zs = 0; ze = gz;
        end else begin
            split_axis(gy, ny, yp, ys, ye);
            split_axis(gz, nz, zp, zs, ze);
        end
        base = xp * plane + yp * nz + zp;
        res.x_start = xs[CELL_W-1:0];
        res.x_end   = xe[CELL_W-1:0];
        res.y_start = ys[CELL_W-1:0];
        res.y_end   = ye[CELL_W-1:0];
        res.z_start = zs[CELL_W-1:0];
        res.z_end   = ze[CELL_W-1:0];
        res.west  = RANK_W'(wrap_down(xp, nx) * plane + yp * nz + zp);
        res.east  = RANK_W'(wrap_up(xp, nx) * plane + yp * nz + zp);
        res.south = RANK_W'(xp * plane + wrap_down(yp, ny) * nz + zp);
        res.north = RANK_W'(xp * plane + wrap_up(yp, ny) * nz + zp);
        res.below = RANK_W'(base - zp + wrap_down(zp, nz));
        res.above = RANK_W'(base - zp + wrap_up(zp, nz));
        return res;
    endfunction

    task automatic send_rank(input logic [RANK_W-1:0] rank);
        while ($urandom_range(99) < send_idle) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push   <= 1'b1;
        i_rank <= rank;
        do @(posedge i_clk); while (full);
        expected_boxes.push_back(predict_box(rank));
    endtask

    task automatic drain;
        push <= 1'b0;
        while (expected_boxes.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_SPLIT_MODE:  split_mode_r  = data[0];
            CFG_TOTAL_PROCS: total_procs_r = data[PROC_W-1:0];
            CFG_PROCS_X:     px_r = data[PROC_W-1:0];
            CFG_PROCS_Y:     py_r = data[PROC_W-1:0];
            CFG_PROCS_Z:     pz_r = data[PROC_W-1:0];
            CFG_GLOBAL_X:    gx_r = data;
            CFG_GLOBAL_Y:    gy_r = data;
            CFG_GLOBAL_Z:    gz_r = data;
            default: ;
        endcase
    endtask

    task automatic load_geometry(input logic mode, input int tp, input int px, input int py,
                                 input int pz, input int gx, input int gy, input int gz);
        drain();
        write_reg(CFG_SPLIT_MODE, CFG_DATA_W'(mode));
        write_reg(CFG_TOTAL_PROCS, CFG_DATA_W'(tp));
        write_reg(CFG_PROCS_X, CFG_DATA_W'(px));
        write_reg(CFG_PROCS_Y, CFG_DATA_W'(py));
        write_reg(CFG_PROCS_Z, CFG_DATA_W'(pz));
        write_reg(CFG_GLOBAL_X, CFG_DATA_W'(gx));
        write_reg(CFG_GLOBAL_Y, CFG_DATA_W'(gy));
        write_reg(CFG_GLOBAL_Z, CFG_DATA_W'(gz));
        i_cfg_we <= 1'b0;
    endtask

    task automatic check_field(input string name, input longint unsigned exp_v,
                               input longint unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s expected %0d actual %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // result side
    initial begin
        t_res want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) begin
                if (expected_boxes.size() == 0) begin
                    $error("result with no pending item");
                    fail_count++;
                end else begin
                    want = expected_boxes.pop_front();
                    check_field("x_start", want.x_start, o_x_start);
                    check_field("x_end", want.x_end, o_x_end);
                    check_field("y_start", want.y_start, o_y_start);
                    check_field("y_end", want.y_end, o_y_end);
                    check_field("z_start", want.z_start, o_z_start);
                    check_field("z_end", want.z_end, o_z_end);
                    check_field("west_rank", want.west, o_west_rank);
                    check_field("east_rank", want.east, o_east_rank);
                    check_field("south_rank", want.south, o_south_rank);
                    check_field("north_rank", want.north, o_north_rank);
                    check_field("below_rank", want.below, o_below_rank);
                    check_field("above_rank", want.above, o_above_rank);
                end
            end
            pop <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic test_reset_values;
        send_rank(0);
        send_rank(1);
        send_rank(10'h3ff);
    endtask

    task automatic test_x_only_split;
        load_geometry(0, 7, 1, 1, 1, 100, 33, 65535);
        send_rank(0); send_rank(3); send_rank(6);
        load_geometry(0, 1024, 5, 5, 5, 65535, 0, 1);
        send_rank(0); send_rank(1023); send_rank(512);
        // zero count and over-limit count
        load_geometry(0, 0, 1, 1, 1, 0, 9, 9);
        send_rank(0); send_rank(5);
        load_geometry(0, 2047, 1, 1, 1, 3, 9, 9);
        send_rank(2); send_rank(1023);
    endtask

    task automatic test_process_grid;
        load_geometry(1, 1, 4, 3, 5, 37, 65535, 11);
        send_rank(0); send_rank(59); send_rank(17); send_rank(33);
        load_geometry(1, 1, 2047, 0, 1, 65535, 1, 0);
        send_rank(0); send_rank(1023);
        load_geometry(1, 1, 1, 1024, 1, 5, 1000, 5);
        send_rank(0); send_rank(1023);
    endtask

    task automatic test_rank_beyond_grid;
        // positions past the extent, wide index products
        load_geometry(1, 1, 3, 2, 2, 65535, 7, 7);
        send_rank(12); send_rank(1023); send_rank(700);
        load_geometry(0, 2, 1, 1, 1, 65535, 1, 1);
        send_rank(5); send_rank(1023);
    endtask

    task automatic random_config;
        int px, py, pz;
        px = $urandom_range(1, 12);
        py = $urandom_range(1, 12);
        pz = $urandom_range(1, 12);
        case ($urandom_range(5))
            0: px = $urandom_range(0, 2047);
            1: pz = $urandom_range(1, 1024);
            default: ;
        endcase
        load_geometry(1'($urandom_range(1)), $urandom_range(0, 1100), px, py, pz,
                      ($urandom_range(3) == 0) ? $urandom_range(0, 65535) : $urandom_range(1, 300),
                      ($urandom_range(3) == 0) ? $urandom_range(0, 65535) : $urandom_range(1, 300),
                      ($urandom_range(3) == 0) ? $urandom_range(0, 65535) : $urandom_range(1, 300));
    endtask

    task automatic test_random_queries(input int count);
        longint unsigned span;
        for (int i = 0; i < count; i++) begin
            if (i % 20 == 0) random_config();
            if (split_mode_r == 0) span = clamp_count(total_procs_r, MAX_PROCS);
            else span = clamp_count(px_r, MAX_PROCS) * clamp_count(py_r, MAX_PROCS)
                        * clamp_count(pz_r, MAX_PROCS);
            if (span > 1024) span = 1024;
            if ($urandom_range(9) < 8) send_rank(RANK_W'($urandom_range(0, 32'(span - 1))));
            else send_rank(RANK_W'($urandom_range(0, 1023)));
        end
    endtask

    initial begin
        split_mode_r = 1; total_procs_r = 1; px_r = 1; py_r = 1; pz_r = 1;
        gx_r = 1; gy_r = 1; gz_r = 1;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle = 34; recv_idle = 62;
        test_reset_values();
        test_x_only_split();
        test_process_grid();
        test_rank_beyond_grid();
        test_random_queries(140);
        send_idle = 62; recv_idle = 34;
        test_random_queries(140);
        send_idle = 0; recv_idle = 0;
        test_random_queries(140);
        drain();
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
